// File: rtl/hesc_pkg.sv
// Shared types, constants and byte tables for the HTML escape stream core.
package hesc_pkg;

  localparam int unsigned CapWidth   = 16;
  localparam int unsigned ChWidth    = 16;
  localparam int unsigned CpWidth    = 21;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QPtrWidth  = 2;

  localparam logic [CpWidth-1:0]  CpLimit  = 21'h10FFFF;
  localparam logic [CapWidth-1:0] CapReset = 16'd1024;

  localparam logic [7:0] ChLt    = 8'h3C;
  localparam logic [7:0] ChGt    = 8'h3E;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChQuot  = 8'h22;
  localparam logic [7:0] ChApos  = 8'h27;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChX     = 8'h78;
  localparam logic [7:0] ChSemi  = 8'h3B;

  typedef enum logic [1:0] {
    STOP_DONE  = 2'd0,
    STOP_ROOM  = 2'd1,
    STOP_UTF8  = 2'd2,
    STOP_RANGE = 2'd3
  } stop_e;

  typedef enum logic [1:0] {
    PK_CHAR    = 2'd0,
    PK_ENTITY  = 2'd1,
    PK_NUMERIC = 2'd2,
    PK_TERM    = 2'd3
  } piece_kind_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        is_terminator;
    logic        last_of_run;
    logic [15:0] chars_written;
    logic [1:0]  stop_reason;
  } out_item_t;

  // One output piece, as the front hands it to the back.
  typedef struct packed {
    piece_kind_e         kind;
    logic [7:0]          ch;
    logic [CpWidth-1:0]  cp;
    logic [3:0]          len;
    logic [2:0]          ndig;
    logic [ChWidth-1:0]  count;
    stop_e               reason;
  } desc_t;

  function automatic logic [3:0] entity_len(input logic [7:0] ch);
    logic [3:0] n;
    n = 4'd6;
    if (ch == ChLt || ch == ChGt) begin
      n = 4'd4;
    end else if (ch == ChAmp) begin
      n = 4'd5;
    end
    return n;
  endfunction

  function automatic logic [7:0] entity_byte(input logic [7:0] ch, input logic [3:0] idx);
    logic [47:0] s;
    logic [47:0] sh;
    s = '0;
    if (ch == ChLt) begin
      s = {"&lt;", 16'h0};
    end else if (ch == ChGt) begin
      s = {"&gt;", 16'h0};
    end else if (ch == ChAmp) begin
      s = {"&amp;", 8'h0};
    end else if (ch == ChQuot) begin
      s = "&quot;";
    end else if (ch == ChApos) begin
      s = "&#x27;";
    end else if (ch == ChSlash) begin
      s = "&#x2F;";
    end
    sh = s << {idx, 3'b000};
    return sh[47:40];
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

// File: rtl/hesc_front.sv
// Front end: takes text words, tracks UTF-8 and room, and issues piece descriptors.
module hesc_front #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  hesc_pkg::in_item_t   in_item_i,
  input  logic                 cfg_write_i,
  input  logic [15:0]          cfg_data_i,
  output logic                 q_push_o,
  output hesc_pkg::desc_t      q_wdata_o
);

  localparam int unsigned ExtW = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

  logic [15:0]                    cap_q, cap_d;
  logic [COUNT_WIDTH-1:0]         room_q, room_d;
  logic [COUNT_WIDTH-1:0]         cnt_q, cnt_d;
  logic [1:0]                     pend_q, pend_d;
  logic [hesc_pkg::CpWidth-1:0]   acc_q, acc_d;
  logic                           halted_q, halted_d;
  hesc_pkg::stop_e                cause_q, cause_d;

  logic [7:0]                     b;
  logic                           eot;
  logic [hesc_pkg::CpWidth-1:0]   acc_new;
  logic [2:0]                     ndig;
  logic                           have_piece;
  logic [3:0]                     plen;
  logic [ExtW-1:0]                cnt_ext;
  hesc_pkg::desc_t                desc;

  // Saturate a capacity to the count width.
  function automatic logic [COUNT_WIDTH-1:0] load_room(input logic [15:0] cap);
    logic [ExtW-1:0] ext;
    ext = ExtW'(cap);
    return ((ext >> COUNT_WIDTH) != '0) ? '1 : ext[COUNT_WIDTH-1:0];
  endfunction

  assign b       = in_item_i.in_byte;
  assign eot     = in_item_i.end_of_text || (b == 8'h00);
  assign acc_new = {acc_q[hesc_pkg::CpWidth-7:0], b[5:0]};
  assign cnt_ext = ExtW'(cnt_q);

  always_comb begin
    priority if (acc_new[20]) begin
      ndig = 3'd6;
    end else if (acc_new[19:16] != 4'h0) begin
      ndig = 3'd5;
    end else if (acc_new[15:12] != 4'h0) begin
      ndig = 3'd4;
    end else if (acc_new[11:8] != 4'h0) begin
      ndig = 3'd3;
    end else if (acc_new[7:4] != 4'h0) begin
      ndig = 3'd2;
    end else begin
      ndig = 3'd1;
    end
  end

  always_comb begin
    cap_d      = cap_q;
    room_d     = room_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    acc_d      = acc_q;
    halted_d   = halted_q;
    cause_d    = cause_q;
    have_piece = 1'b0;
    plen       = 4'd1;
    q_push_o   = 1'b0;
    desc       = '0;
    desc.ch    = b;
    desc.cp    = acc_new;
    desc.ndig  = ndig;
    desc.count = cnt_ext[15:0];

    if (cfg_write_i) begin
      cap_d    = cfg_data_i;
      room_d   = load_room(cfg_data_i);
      cnt_d    = '0;
      pend_d   = '0;
      acc_d    = '0;
      halted_d = 1'b0;
      cause_d  = hesc_pkg::STOP_DONE;
    end else if (accept_i) begin
      if (eot) begin
        desc.kind = hesc_pkg::PK_TERM;
        desc.len  = 4'd1;
        if (halted_q) begin
          desc.reason = cause_q;
        end else if (pend_q != 2'd0) begin
          desc.reason = hesc_pkg::STOP_UTF8;
        end else begin
          desc.reason = hesc_pkg::STOP_DONE;
        end
        q_push_o = 1'b1;
        room_d   = load_room(cap_q);
        cnt_d    = '0;
        pend_d   = '0;
        acc_d    = '0;
        halted_d = 1'b0;
        cause_d  = hesc_pkg::STOP_DONE;
      end else if (!halted_q) begin
        if (pend_q != 2'd0) begin
          if (b[7:6] != 2'b10) begin
            halted_d = 1'b1;
            cause_d  = hesc_pkg::STOP_UTF8;
          end else begin
            pend_d = pend_q - 2'd1;
            acc_d  = acc_new;
            if (pend_q == 2'd1) begin
              acc_d = '0;
              if (acc_new > hesc_pkg::CpLimit) begin
                halted_d = 1'b1;
                cause_d  = hesc_pkg::STOP_RANGE;
              end else if (acc_new != '0) begin
                have_piece = 1'b1;
                desc.kind  = hesc_pkg::PK_NUMERIC;
                plen       = 4'd4 + {1'b0, ndig};
              end
            end
          end
        end else if (b == hesc_pkg::ChLt || b == hesc_pkg::ChGt || b == hesc_pkg::ChAmp
                     || b == hesc_pkg::ChQuot || b == hesc_pkg::ChApos
                     || b == hesc_pkg::ChSlash) begin
          have_piece = 1'b1;
          desc.kind  = hesc_pkg::PK_ENTITY;
          plen       = hesc_pkg::entity_len(b);
        end else if (!b[7]) begin
          have_piece = 1'b1;
          desc.kind  = hesc_pkg::PK_CHAR;
          plen       = 4'd1;
        end else if (b[7:5] == 3'b110) begin
          acc_d  = {16'h0, b[4:0]};
          pend_d = 2'd1;
        end else if (b[7:4] == 4'b1110) begin
          acc_d  = {17'h0, b[3:0]};
          pend_d = 2'd2;
        end else if (b[7:3] == 5'b11110) begin
          acc_d  = {18'h0, b[2:0]};
          pend_d = 2'd3;
        end
        // Stray continuation and invalid lead bytes fall through and drop.

        if (have_piece) begin
          desc.len = plen;
          if (room_q <= COUNT_WIDTH'(plen)) begin
            halted_d = 1'b1;
            cause_d  = hesc_pkg::STOP_ROOM;
          end else begin
            q_push_o = 1'b1;
            room_d   = room_q - COUNT_WIDTH'(plen);
            cnt_d    = cnt_q + COUNT_WIDTH'(plen);
          end
        end
      end
    end
  end

  assign q_wdata_o = desc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= hesc_pkg::CapReset;
      room_q   <= load_room(hesc_pkg::CapReset);
      cnt_q    <= '0;
      pend_q   <= '0;
      acc_q    <= '0;
      halted_q <= 1'b0;
      cause_q  <= hesc_pkg::STOP_DONE;
    end else begin
      cap_q    <= cap_d;
      room_q   <= room_d;
      cnt_q    <= cnt_d;
      pend_q   <= pend_d;
      acc_q    <= acc_d;
      halted_q <= halted_d;
      cause_q  <= cause_d;
    end
  end

endmodule

// File: rtl/hesc_queue.sv
// Short descriptor queue between the front and back ends.
module hesc_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  hesc_pkg::desc_t  wdata_i,
  input  logic             pop_i,
  output hesc_pkg::desc_t  rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  hesc_pkg::desc_t                   mem_q [hesc_pkg::QueueDepth];
  logic [hesc_pkg::QPtrWidth-1:0]    wr_q, rd_q;
  logic [hesc_pkg::QPtrWidth:0]      cnt_q;

  assign full_o  = (cnt_q == (hesc_pkg::QPtrWidth + 1)'(hesc_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign rdata_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

// File: rtl/hesc_back.sv
// Back end: expands descriptors into output bytes, one word per cycle while the output is popped.
module hesc_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  hesc_pkg::desc_t      q_rdata_i,
  input  logic                 q_empty_i,
  output logic                 q_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output hesc_pkg::out_item_t  out_item_o
);

  logic [3:0]           idx_q, idx_d;
  logic                 valid_q, valid_d;
  hesc_pkg::out_item_t  out_q, out_d;
  logic                 advance, load, last;
  logic [2:0]           ni;
  logic [3:0]           nib;
  logic [7:0]           obyte;
  hesc_pkg::desc_t      d;

  assign d       = q_rdata_i;
  assign advance = !valid_q || pop_i;
  assign load    = advance && !q_empty_i;
  assign last    = (idx_q == d.len - 4'd1);
  assign q_pop_o = load && last;
  // Digits run most significant first, after the three prefix bytes.
  assign ni      = 3'(d.ndig + 3'd2 - idx_q[2:0]);

  always_comb begin
    unique case (ni)
      3'd0:    nib = d.cp[3:0];
      3'd1:    nib = d.cp[7:4];
      3'd2:    nib = d.cp[11:8];
      3'd3:    nib = d.cp[15:12];
      3'd4:    nib = d.cp[19:16];
      default: nib = {3'b000, d.cp[20]};
    endcase
  end

  always_comb begin
    unique case (d.kind)
      hesc_pkg::PK_CHAR:    obyte = d.ch;
      hesc_pkg::PK_ENTITY:  obyte = hesc_pkg::entity_byte(d.ch, idx_q);
      hesc_pkg::PK_NUMERIC: begin
        if (idx_q == 4'd0) begin
          obyte = hesc_pkg::ChAmp;
        end else if (idx_q == 4'd1) begin
          obyte = hesc_pkg::ChHash;
        end else if (idx_q == 4'd2) begin
          obyte = hesc_pkg::ChX;
        end else if (last) begin
          obyte = hesc_pkg::ChSemi;
        end else begin
          obyte = hesc_pkg::hex_char(nib);
        end
      end
      default:              obyte = 8'h00;
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    out_d   = out_q;
    if (load) begin
      valid_d             = 1'b1;
      idx_d               = last ? 4'd0 : idx_q + 4'd1;
      out_d.out_byte      = obyte;
      out_d.last_of_run   = last;
      out_d.is_terminator = (d.kind == hesc_pkg::PK_TERM);
      out_d.chars_written = (d.kind == hesc_pkg::PK_TERM) ? d.count : '0;
      out_d.stop_reason   = (d.kind == hesc_pkg::PK_TERM) ? d.reason : hesc_pkg::STOP_DONE;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty_o    = !valid_q;
  assign out_item_o = out_q;

endmodule

// File: rtl/html_escape_utf8_stream_core.sv
// Path: an accepted text word passes the descriptor queue, then the output register.
// Throughput: one result word per cycle while output is popped; plain bytes sustain
// one text word per cycle, an entity or numeric reference holds the back end until
// all its bytes are out, and the four-entry queue sets how far the front may run ahead.
// Reset: descriptor queue empty, stream state cleared, capacity register loads 1024.
module html_escape_utf8_stream_core #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  hesc_pkg::in_item_t   in_item_i,
  output logic                 empty,
  input  logic                 pop,
  output hesc_pkg::out_item_t  out_item_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [15:0]          cfg_data_i
);

  logic             q_push, q_pop, q_full, q_empty, accept;
  hesc_pkg::desc_t  q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;
  assign full        = q_full;
  assign accept      = push && !q_full;

  hesc_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_item_i   (in_item_i),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .q_push_o    (q_push),
    .q_wdata_o   (q_wdata)
  );

  hesc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  hesc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_rdata_i  (q_rdata),
    .q_empty_i  (q_empty),
    .q_pop_o    (q_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("descriptor pushed into a full queue");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty)
    else $error("descriptor popped from an empty queue");

  a_term_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.is_terminator) |-> out_item_o.last_of_run)
    else $error("terminator word not marked last of run");

  a_text_no_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !out_item_o.is_terminator)
      |-> (out_item_o.chars_written == '0 && out_item_o.stop_reason == '0))
    else $error("status fields set on a text word");

endmodule
